### rtl/ckpt_pkg.sv
// ----------------------------------------------------------------------------
// ckpt_pkg: shared types and constants for the point tracker
// Request structs for the shared multiplier and divider, rounding shift
// codes and the saturation helpers.
// ----------------------------------------------------------------------------
package ckpt_pkg;

  // rounding shift applied to a product
  typedef logic [2:0] shift_t;
  localparam shift_t SH_0  = 3'd0;
  localparam shift_t SH_11 = 3'd1;
  localparam shift_t SH_12 = 3'd2;
  localparam shift_t SH_24 = 3'd3;
  localparam shift_t SH_30 = 3'd4;

  localparam int MUL_RES_W = 62;
  // product magnitude clamp, 2^60
  localparam logic [60:0] MUL_LIM = 61'h1000_0000_0000_0000;
  // 1.0 in Q18.30
  localparam logic signed [47:0] COV_ONE = 48'sh0000_4000_0000;
  localparam logic [47:0] LIM48 = 48'h7FFF_FFFF_FFFF;

  typedef struct packed {
    logic              start;
    logic signed [48:0] a;
    logic signed [48:0] b;
    shift_t            shift;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic signed [47:0] num0;
    logic signed [47:0] num1;
    logic [47:0]       den;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > 64'sd140737488355327)       r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -64'sd140737488355328) r = 48'sh8000_0000_0000;
    else                                r = v[47:0];
    return r;
  endfunction

endpackage

### rtl/ckpt_mul.sv
// ----------------------------------------------------------------------------
// ckpt_mul: shared multiplier
// Sign-magnitude product, 48 x 16 bits a cycle from the top chunk down, then
// a rounding step (half away from zero), clamp to 2^60 and sign.
// ----------------------------------------------------------------------------
module ckpt_mul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ckpt_pkg::mul_req_t       req,
  output logic                     done,
  output logic signed [61:0]       res
);
  import ckpt_pkg::*;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_RND  = 2'd2;

  logic [1:0]         phase_r;
  logic [47:0]        a_r, b_r;
  logic [95:0]        acc_r;
  logic [1:0]         cnt_r;
  logic               neg_r;
  shift_t             sh_r;
  logic               done_r;
  logic signed [61:0] res_r;

  logic [47:0] a_mag, b_mag, b_align;
  logic [48:0] a_neg, b_neg;
  logic [1:0]  cnt_init;
  logic [63:0] prod;
  logic [95:0] acc_step, rnd_add;
  logic [6:0]  sh_amt;
  logic [96:0] rsum, mq;
  logic [60:0] mclamp;
  logic signed [61:0] res_nxt;

  always_comb begin
    a_neg = -req.a;
    b_neg = -req.b;
    a_mag = req.a[48] ? a_neg[47:0] : req.a[47:0];
    b_mag = req.b[48] ? b_neg[47:0] : req.b[47:0];
    if (b_mag[47:32] != 16'd0)      cnt_init = 2'd2;
    else if (b_mag[31:16] != 16'd0) cnt_init = 2'd1;
    else                            cnt_init = 2'd0;
    case (cnt_init)
      2'd2:    b_align = b_mag;
      2'd1:    b_align = {b_mag[31:0], 16'd0};
      default: b_align = {b_mag[15:0], 32'd0};
    endcase
    prod     = {16'd0, a_r} * {48'd0, b_r[47:32]};
    acc_step = {acc_r[79:0], 16'd0} + {32'd0, prod};
    unique case (sh_r)
      SH_11:   begin sh_amt = 7'd11; rnd_add = 96'd1 << 10; end
      SH_12:   begin sh_amt = 7'd12; rnd_add = 96'd1 << 11; end
      SH_24:   begin sh_amt = 7'd24; rnd_add = 96'd1 << 23; end
      SH_30:   begin sh_amt = 7'd30; rnd_add = 96'd1 << 29; end
      default: begin sh_amt = 7'd0;  rnd_add = 96'd0;       end
    endcase
    rsum   = {1'b0, acc_r} + {1'b0, rnd_add};
    mq     = rsum >> sh_amt;
    mclamp = (mq > {36'd0, MUL_LIM}) ? MUL_LIM : mq[60:0];
    res_nxt = neg_r ? -$signed({1'b0, mclamp}) : $signed({1'b0, mclamp});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        P_IDLE: begin
          if (req.start) begin
            a_r     <= a_mag;
            b_r     <= b_align;
            cnt_r   <= cnt_init;
            acc_r   <= '0;
            neg_r   <= req.a[48] ^ req.b[48];
            sh_r    <= req.shift;
            phase_r <= P_MUL;
          end
        end
        P_MUL: begin
          acc_r <= acc_step;
          b_r   <= {b_r[31:0], 16'd0};
          if (cnt_r == 2'd0) phase_r <= P_RND;
          else               cnt_r   <= cnt_r - 2'd1;
        end
        P_RND: begin
          res_r   <= res_nxt;
          done_r  <= 1'b1;
          phase_r <= P_IDLE;
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### rtl/ckpt_div.sv
// ----------------------------------------------------------------------------
// ckpt_div: dual-lane gain divider
// Both gains share one divisor: (num * 2^30) / den toward zero, one quotient
// bit per lane per cycle, saturated to 48 bits.
// ----------------------------------------------------------------------------
module ckpt_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ckpt_pkg::div_req_t       req,
  output logic                     done,
  output logic signed [47:0]       q0,
  output logic signed [47:0]       q1
);
  import ckpt_pkg::*;

  localparam int          NBITS = 48;
  localparam logic [5:0]  LAST  = 6'(NBITS - 1);

  logic              busy_r, done_r;
  logic [5:0]        cnt_r;
  logic [47:0]       den_r;
  logic [47:0]       rem_r  [2];
  logic [47:0]       feed_r [2];
  logic [47:0]       quo_r  [2];
  logic              ovf_r  [2];
  logic              neg_r  [2];
  logic signed [47:0] res_r [2];

  logic signed [47:0] num    [2];
  logic [47:0]        n_mag  [2];
  logic [48:0]        r2     [2];
  logic [48:0]        r2_sub [2];
  logic               qbit   [2];
  logic [47:0]        q_fin  [2];
  logic [47:0]        quo_nx [2];

  always_comb begin
    num[0] = req.num0;
    num[1] = req.num1;
    for (int l = 0; l < 2; l++) begin
      n_mag[l]  = num[l][47] ? 48'(-num[l]) : num[l];
      r2[l]     = {rem_r[l], feed_r[l][47]};
      r2_sub[l] = r2[l] - {1'b0, den_r};
      qbit[l]   = (r2[l] >= {1'b0, den_r});
      quo_nx[l] = {quo_r[l][46:0], qbit[l]};
      q_fin[l]  = (ovf_r[l] || quo_nx[l][47]) ? LIM48 : quo_nx[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          den_r  <= req.den;
          for (int l = 0; l < 2; l++) begin
            rem_r[l]  <= {18'd0, n_mag[l][47:18]};
            feed_r[l] <= {n_mag[l][17:0], 30'd0};
            quo_r[l]  <= '0;
            ovf_r[l]  <= ({18'd0, n_mag[l][47:18]} >= req.den);
            neg_r[l]  <= num[l][47];
          end
        end
      end else begin
        for (int l = 0; l < 2; l++) begin
          rem_r[l]  <= qbit[l] ? r2_sub[l][47:0] : r2[l][47:0];
          feed_r[l] <= {feed_r[l][46:0], 1'b0};
          quo_r[l]  <= quo_nx[l];
        end
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          for (int l = 0; l < 2; l++)
            res_r[l] <= neg_r[l] ? -$signed(q_fin[l]) : $signed(q_fin[l]);
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign q0   = res_r[0];
  assign q1   = res_r[1];

endmodule

### rtl/cv_kalman_point_tracker_unit.sv
// ----------------------------------------------------------------------------
// cv_kalman_point_tracker_unit: two-axis constant-velocity Kalman tracker
// One measured point in, one updated estimate out. Each axis is filtered in
// turn through one shared multiplier and one dual-lane gain divider.
//
//  channel | dir | transfer contents
//  --------+-----+-------------------------------------------------------
//  in_     | in  | tdata: meas_x, meas_y; tuser: restart
//  out_    | out | tdata: est_x, est_y, err_x, err_y; tuser: err_valid
//  cfg_    | in  | write of step time, q noise, r noise,
//          |     | start x, start y (index 0..4)
//
//  Items are taken one at a time. Between input transfers the sequencer runs, per
//  axis, one error step, ten chunked products (each through the shared
//  multiplier, its length set by the width of the second operand) and one
//  gain division, then one output step and one idle accept step.
//  in_tready is high only while the sequencer is idle.
//  The result sits in an output register; a stalled out_ side holds the
//  sequencer at its last step until the register frees.
//  Reset (rst_n low, synchronous) loads the default registers and the
//  start state: start position, zero velocity, identity covariance.
// ----------------------------------------------------------------------------
module cv_kalman_point_tracker_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // [15:0] meas_x, [31:16] meas_y
  input  logic         in_tuser,   // [0] restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // est_x, est_y, err_x, err_y, 32b each
  output logic         out_tuser,  // [0] err_valid
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [29:0]  cfg_wdata
);
  import ckpt_pkg::*;

  // register indexes
  localparam logic [2:0] REG_STEP   = 3'd0;
  localparam logic [2:0] REG_QNOISE = 3'd1;
  localparam logic [2:0] REG_RNOISE = 3'd2;
  localparam logic [2:0] REG_STARTX = 3'd3;
  localparam logic [2:0] REG_STARTY = 3'd4;

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ERR      = 3'd1;
  localparam logic [2:0] S_MUL_GO   = 3'd2;
  localparam logic [2:0] S_MUL_WAIT = 3'd3;
  localparam logic [2:0] S_DIV_GO   = 3'd4;
  localparam logic [2:0] S_DIV_WAIT = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  // product steps, in issue order
  localparam logic [3:0] OP_VDT   = 4'd0;  // v*dt
  localparam logic [3:0] OP_PVDT  = 4'd1;  // 2*pv*dt
  localparam logic [3:0] OP_DTSQ  = 4'd2;  // dt*dt
  localparam logic [3:0] OP_VVDT2 = 4'd3;  // vv*dt*dt
  localparam logic [3:0] OP_VVDT  = 4'd4;  // vv*dt
  localparam logic [3:0] OP_K0Y   = 4'd5;
  localparam logic [3:0] OP_K1Y   = 4'd6;
  localparam logic [3:0] OP_K0PP  = 4'd7;
  localparam logic [3:0] OP_K0PV  = 4'd8;
  localparam logic [3:0] OP_K1PV  = 4'd9;

  // configuration
  logic [15:0]        step_r;
  logic [29:0]        qnoise_r, rnoise_r;
  logic signed [15:0] startx_r, starty_r;

  // filter state, one entry per axis
  logic signed [31:0] pos_r [2];
  logic signed [31:0] vel_r [2];
  logic signed [47:0] cpp_r [2];
  logic signed [47:0] cpv_r [2];
  logic signed [47:0] cvv_r [2];
  logic               seen_r;

  // sequencer and working registers
  logic [2:0]         state_r, state_nxt;
  logic [3:0]         op_r;
  logic               ax_r;
  logic               valid_r;
  logic signed [15:0] meas_r [2];
  logic signed [31:0] z_r;
  logic signed [31:0] err_r [2];
  logic signed [31:0] xp_r;
  logic signed [63:0] acc_r;
  logic [31:0]        dtsq_r;
  logic signed [47:0] ppp_r, pvp_r, vvp_r;
  logic signed [32:0] y_r;
  logic signed [47:0] k0_r, k1_r;
  logic               out_valid_r;
  logic [127:0]       out_data_r;
  logic               out_user_r;

  mul_req_t           mul_req;
  div_req_t           div_req;
  logic               mul_done, div_done;
  logic signed [61:0] mul_res;
  logic signed [47:0] div_q0, div_q1;

  logic signed [31:0] pos_c, vel_c, zq;
  logic signed [47:0] cpp_c, cpv_c, cvv_c;
  logic signed [63:0] qn, err_dif, xp_sum, ppp_sum, pvp_sum, vvp_sum;
  logic signed [63:0] pos_sum, vel_sum, cpp_dif, cpv_dif, cvv_dif;
  logic signed [63:0] mres64;
  logic signed [48:0] dt_s, s_sum;
  logic [47:0]        den;
  logic               in_acc, out_free;

  ckpt_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .res   (mul_res)
  );

  ckpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .q0    (div_q0),
    .q1    (div_q1)
  );

  assign in_acc   = in_tvalid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;

  // current-axis views and the sums that follow each product
  always_comb begin
    pos_c   = pos_r[ax_r];
    vel_c   = vel_r[ax_r];
    cpp_c   = cpp_r[ax_r];
    cpv_c   = cpv_r[ax_r];
    cvv_c   = cvv_r[ax_r];
    zq      = {meas_r[ax_r], 16'd0};
    qn      = $signed({34'd0, qnoise_r});
    dt_s    = $signed({33'd0, step_r});
    mres64  = 64'(mul_res);
    err_dif = 64'(pos_c) - 64'(zq);
    xp_sum  = 64'(pos_c) + mres64;
    ppp_sum = 64'(cpp_c) + acc_r + qn;
    pvp_sum = 64'(cpv_c) + mres64;
    vvp_sum = 64'(cvv_c) + qn;
    pos_sum = 64'(xp_r) + mres64;
    vel_sum = 64'(vel_c) + mres64;
    cpp_dif = 64'(ppp_r) - mres64;
    cpv_dif = 64'(pvp_r) - mres64;
    cvv_dif = 64'(vvp_r) - mres64;
    // innovation variance, at least one LSB
    s_sum   = 49'(ppp_r) + $signed({19'd0, rnoise_r});
    den     = (s_sum < 49'sd1) ? 48'd1 : s_sum[47:0];
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_req.start = (state_r == S_MUL_GO);
    mul_req.a     = dt_s;
    mul_req.b     = dt_s;
    mul_req.shift = SH_0;
    unique case (op_r)
      OP_VDT:   begin mul_req.a = 49'(vel_c); mul_req.shift = SH_12; end
      OP_PVDT:  begin mul_req.a = 49'(cpv_c); mul_req.shift = SH_11; end
      OP_DTSQ:  mul_req.shift = SH_0;
      OP_VVDT2: begin
        mul_req.a     = 49'(cvv_c);
        mul_req.b     = $signed({17'd0, dtsq_r});
        mul_req.shift = SH_24;
      end
      OP_VVDT:  begin mul_req.a = 49'(cvv_c); mul_req.shift = SH_12; end
      OP_K0Y:   begin
        mul_req.a = 49'(k0_r); mul_req.b = 49'(y_r); mul_req.shift = SH_30;
      end
      OP_K1Y:   begin
        mul_req.a = 49'(k1_r); mul_req.b = 49'(y_r); mul_req.shift = SH_30;
      end
      OP_K0PP:  begin
        mul_req.a = 49'(k0_r); mul_req.b = 49'(ppp_r); mul_req.shift = SH_30;
      end
      OP_K0PV:  begin
        mul_req.a = 49'(k0_r); mul_req.b = 49'(pvp_r); mul_req.shift = SH_30;
      end
      OP_K1PV:  begin
        mul_req.a = 49'(k1_r); mul_req.b = 49'(pvp_r); mul_req.shift = SH_30;
      end
      default:  mul_req.shift = SH_0;
    endcase
    div_req.start = (state_r == S_DIV_GO);
    div_req.num0  = ppp_r;
    div_req.num1  = pvp_r;
    div_req.den   = den;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = S_ERR;
      S_ERR:      state_nxt = S_MUL_GO;
      S_MUL_GO:   state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul_done) begin
          if (op_r == OP_VVDT)      state_nxt = S_DIV_GO;
          else if (op_r == OP_K1PV) state_nxt = ax_r ? S_DONE : S_ERR;
          else                      state_nxt = S_MUL_GO;
        end
      end
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_nxt = S_MUL_GO;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_VDT;
      ax_r        <= 1'b0;
      valid_r     <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= 16'd2253;
      qnoise_r    <= 30'd107374;
      rnoise_r    <= 30'd10737418;
      startx_r    <= 16'sd200;
      starty_r    <= 16'sd150;
      pos_r[0]    <= {16'sd200, 16'd0};
      pos_r[1]    <= {16'sd150, 16'd0};
      for (int a = 0; a < 2; a++) begin
        vel_r[a] <= '0;
        cpp_r[a] <= COV_ONE;
        cpv_r[a] <= '0;
        cvv_r[a] <= COV_ONE;
      end
      seen_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_STEP:   step_r   <= cfg_wdata[15:0];
          REG_QNOISE: qnoise_r <= cfg_wdata;
          REG_RNOISE: rnoise_r <= cfg_wdata;
          REG_STARTX: startx_r <= cfg_wdata[15:0];
          REG_STARTY: starty_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      // the output step reloads the register itself
      if (out_valid_r && out_tready && (state_r != S_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            meas_r[0] <= in_tdata[15:0];
            meas_r[1] <= in_tdata[31:16];
            ax_r      <= 1'b0;
            if (in_tuser) begin
              // restart: reload start state before the measurement
              pos_r[0] <= {startx_r, 16'd0};
              pos_r[1] <= {starty_r, 16'd0};
              for (int a = 0; a < 2; a++) begin
                vel_r[a] <= '0;
                cpp_r[a] <= COV_ONE;
                cpv_r[a] <= '0;
                cvv_r[a] <= COV_ONE;
              end
              valid_r <= 1'b0;
            end else begin
              valid_r <= seen_r;
            end
          end
        end
        S_ERR: begin
          z_r         <= zq;
          err_r[ax_r] <= valid_r ? sat32(err_dif) : 32'sd0;
          op_r        <= OP_VDT;
        end
        S_MUL_WAIT: begin
          if (mul_done) begin
            op_r <= op_r + 4'd1;
            unique case (op_r)
              OP_VDT:   xp_r   <= sat32(xp_sum);
              OP_PVDT:  acc_r  <= mres64;
              OP_DTSQ:  dtsq_r <= mul_res[31:0];
              OP_VVDT2: acc_r  <= acc_r + mres64;
              OP_VVDT:  begin
                ppp_r <= sat48(ppp_sum);
                pvp_r <= sat48(pvp_sum);
                vvp_r <= sat48(vvp_sum);
              end
              OP_K0Y:   pos_r[ax_r] <= sat32(pos_sum);
              OP_K1Y:   vel_r[ax_r] <= sat32(vel_sum);
              OP_K0PP:  cpp_r[ax_r] <= sat48(cpp_dif);
              OP_K0PV:  cpv_r[ax_r] <= sat48(cpv_dif);
              OP_K1PV:  begin
                cvv_r[ax_r] <= sat48(cvv_dif);
                ax_r        <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_DIV_GO: y_r <= $signed({z_r[31], z_r}) - $signed({xp_r[31], xp_r});
        S_DIV_WAIT: begin
          if (div_done) begin
            k0_r <= div_q0;
            k1_r <= div_q1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= {err_r[1], err_r[0], pos_r[1], pos_r[0]};
            out_user_r  <= valid_r;
            out_valid_r <= 1'b1;
            seen_r      <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // shared units only answer while the sequencer waits on them
  a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL_WAIT)
    else $error("multiplier done outside its wait step");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider done outside its wait step");

  // a restart item never reports an error against the old track
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !valid_r)
    else $error("restart left err_valid set");

  // a finished item is never dropped onto a full output register
  a_done_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) && out_valid_r && !out_tready |=> state_r == S_DONE)
    else $error("result left while output register was full");

endmodule
